// ===== hdl/lcht_pkg.sv =====
// Shared types and constants for the line envelope tree.
// No dependencies; the cell, the top level and the testbench import this package.
package lcht_pkg;

    localparam int DOMAIN_SPAN_DEF = 1024;
    localparam int NODE_COUNT_DEF  = 4096;
    // widest node index over the parameter range, plus one bit for the child
    localparam int IDX_W_MAX       = 23;

    localparam logic [31:0] EMPTY_INTERCEPT = 32'd1000000000;

    localparam logic [1:0] CFG_DOMAIN_LOW  = 2'd0;
    localparam logic [1:0] CFG_DOMAIN_HIGH = 2'd1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [31:0] position;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] minimum;
        logic               out_of_range;
    } out_word_t;

    // operation walking down the row of level cells
    typedef struct packed {
        logic                 valid;
        logic                 is_query;
        logic signed [31:0]   k;
        logic signed [31:0]   b;
        logic signed [31:0]   pos;
        logic signed [31:0]   l;
        logic signed [31:0]   r;
        logic [IDX_W_MAX-1:0] idx;
        logic signed [63:0]   best;
    } token_t;

    typedef struct packed {
        logic               valid;
        logic               is_query;
        logic signed [63:0] best;
    } done_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W_MAX-1:0] addr;
    } clr_t;

endpackage

// ===== hdl/lcht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lcht_cell.sv =====
// One tree level: holds that level's node lines and processes a passing word.
// Depends on lcht_pkg and lcht_ram.
module lcht_cell import lcht_pkg::*; #(
    parameter int LEVEL      = 0,
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  clr_t   clr,
    input  token_t tok_in,
    output token_t tok_out,
    output done_t  done
);

    localparam int ADDR_W = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH  = 1 << ADDR_W;

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_DEC} cstate_t;

    cstate_t            state_reg;
    token_t             tok_reg;
    logic signed [31:0] m_reg;
    logic               leaf_reg;
    logic signed [31:0] sk_reg;
    logic signed [31:0] sb_reg;
    logic signed [63:0] prod_s_reg;
    logic signed [63:0] prod_n_reg;
    token_t             tok_out_reg;
    done_t              done_reg;

    logic [63:0]        rdata;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [63:0]        wdata;

    logic signed [32:0] sum;
    logic signed [32:0] sum_adj;
    logic signed [32:0] span;
    logic signed [31:0] m_next;
    logic signed [31:0] x;
    logic signed [31:0] rd_k;
    logic signed [63:0] vs;
    logic signed [63:0] vn;
    logic               swap;
    logic signed [31:0] keep_k;
    logic signed [31:0] carry_k;
    logic signed [31:0] carry_b;
    logic               go_right;
    logic [IDX_W_MAX-1:0] child;
    logic               stop;
    logic signed [63:0] best_next;

    // midpoint truncated toward zero
    always_comb
    begin
        sum     = {tok_in.l[31], tok_in.l} + {tok_in.r[31], tok_in.r};
        sum_adj = sum + {32'd0, sum[32] & sum[0]};
        m_next  = sum_adj[32:1];
        span    = {tok_in.r[31], tok_in.r} - {tok_in.l[31], tok_in.l};
    end

    always_comb
    begin
        x    = tok_reg.is_query ? tok_reg.pos : m_reg;
        rd_k = rdata[63:32];
    end

    always_comb
    begin
        vs      = prod_s_reg + {{32{sb_reg[31]}}, sb_reg};
        vn      = prod_n_reg + {{32{tok_reg.b[31]}}, tok_reg.b};
        swap    = vn < vs;
        keep_k  = swap ? tok_reg.k : sk_reg;
        carry_k = swap ? sk_reg : tok_reg.k;
        carry_b = swap ? sb_reg : tok_reg.b;
        if (tok_reg.is_query)
        begin
            go_right = !(tok_reg.pos < m_reg);
        end
        else
        begin
            go_right = carry_k < keep_k;
        end
        child = {tok_reg.idx[IDX_W_MAX-2:0], go_right};
        stop  = leaf_reg || (child >= IDX_W_MAX'(NODE_COUNT));
        if (LEVEL == 0)
        begin
            best_next = vs;
        end
        else
        begin
            best_next = (vs < tok_reg.best) ? vs : tok_reg.best;
        end
    end

    always_comb
    begin
        we    = clr.en || (state_reg == C_DEC && !tok_reg.is_query && swap);
        waddr = clr.en ? clr.addr[ADDR_W-1:0] : tok_reg.idx[ADDR_W-1:0];
        wdata = clr.en ? {32'd0, EMPTY_INTERCEPT} : {tok_reg.k, tok_reg.b};
    end

    lcht_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (tok_in.idx[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            tok_reg     <= '0;
            m_reg       <= '0;
            leaf_reg    <= 1'b0;
            sk_reg      <= '0;
            sb_reg      <= '0;
            prod_s_reg  <= '0;
            prod_n_reg  <= '0;
            tok_out_reg <= '0;
            done_reg    <= '0;
        end
        else
        begin
            tok_out_reg.valid <= 1'b0;
            done_reg.valid    <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (tok_in.valid)
                    begin
                        tok_reg   <= tok_in;
                        m_reg     <= m_next;
                        leaf_reg  <= span <= 33'sd1;
                        state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    sk_reg     <= rd_k;
                    sb_reg     <= rdata[31:0];
                    prod_s_reg <= rd_k * x;
                    prod_n_reg <= tok_reg.k * x;
                    state_reg  <= C_DEC;
                end
                C_DEC:
                begin
                    if (stop)
                    begin
                        done_reg.valid    <= 1'b1;
                        done_reg.is_query <= tok_reg.is_query;
                        done_reg.best     <= best_next;
                    end
                    else
                    begin
                        tok_out_reg.valid    <= 1'b1;
                        tok_out_reg.is_query <= tok_reg.is_query;
                        tok_out_reg.k        <= carry_k;
                        tok_out_reg.b        <= carry_b;
                        tok_out_reg.pos      <= tok_reg.pos;
                        tok_out_reg.l        <= go_right ? m_reg : tok_reg.l;
                        tok_out_reg.r        <= go_right ? tok_reg.r : m_reg;
                        tok_out_reg.idx      <= child;
                        tok_out_reg.best     <= best_next;
                    end
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign tok_out = tok_out_reg;
    assign done    = done_reg;

endmodule

// ===== hdl/min_line_envelope_tree_top.sv =====
// Top level of the line envelope tree: config registers, control, row of level cells.
// Depends on lcht_pkg and lcht_cell.
//
// Keeps the lower envelope of lines over [domain_low, domain_high) as a Li Chao
// tree, one cell per tree level, each cell owning that level's node memory. A word
// walks down the cells; each level reads its node, multiplies, then compares and
// writes. A domain of span s touches clog2(s)+1 levels; one word is in flight at a
// time, and a query result then sits in the output register while the next word
// is taken. Inserts with an invalid domain are dropped without entering the cells,
// and out-of-domain queries go straight to the output hold state. After reset a
// clearing pass loads every node with the empty line; input stalls meanwhile,
// config writes are taken at any time.
module min_line_envelope_tree_top import lcht_pkg::*; #(
    parameter int DOMAIN_SPAN = DOMAIN_SPAN_DEF,
    parameter int NODE_COUNT  = NODE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LEVELS = $clog2(NODE_COUNT);
    localparam int CLR_W  = LEVELS - 1;

    typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_BUSY, T_HOLD} tstate_t;

    tstate_t            state_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic signed [31:0] low_reg;
    logic signed [31:0] high_reg;
    token_t             start_reg;
    out_word_t          pend_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    token_t             tok [LEVELS+1];
    done_t              dn  [LEVELS];
    done_t              done_any;
    clr_t               clr;

    logic signed [32:0] span;
    logic               dom_ok;
    logic               in_range;
    logic               accept;
    logic               out_free;

    always_comb
    begin
        span     = {high_reg[31], high_reg} - {low_reg[31], low_reg};
        dom_ok   = (span >= 33'sd1) && (span <= 33'(DOMAIN_SPAN));
        in_range = (in_word.position >= low_reg) && (in_word.position < high_reg);
        in_stall = state_reg != T_IDLE;
        accept   = in_valid && !in_stall;
        out_free = !out_valid_reg || !out_stall;
        clr.en   = state_reg == T_CLEAR;
        clr.addr = IDX_W_MAX'(clr_cnt_reg);
    end

    // at most one cell reports in any cycle
    always_comb
    begin
        done_any = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (dn[i].valid)
            begin
                done_any = dn[i];
            end
        end
    end

    assign tok[0] = start_reg;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        lcht_cell #(
            .LEVEL      (g),
            .NODE_COUNT (NODE_COUNT)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (clr),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .done    (dn[g])
        );
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= 32'sd0;
            high_reg <= 32'sd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DOMAIN_LOW:  low_reg  <= cfg_data;
                CFG_DOMAIN_HIGH: high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            start_reg.valid <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE:
                begin
                    if (accept)
                    begin
                        start_reg.is_query <= in_word.kind == KIND_QUERY;
                        start_reg.k        <= in_word.slope;
                        start_reg.b        <= in_word.intercept;
                        start_reg.pos      <= in_word.position;
                        start_reg.l        <= low_reg;
                        start_reg.r        <= high_reg;
                        start_reg.idx      <= IDX_W_MAX'(1);
                        start_reg.best     <= '0;
                        if (in_word.kind == KIND_INSERT)
                        begin
                            if (dom_ok)
                            begin
                                start_reg.valid <= 1'b1;
                                state_reg       <= T_BUSY;
                            end
                        end
                        else if (dom_ok && in_range)
                        begin
                            start_reg.valid <= 1'b1;
                            state_reg       <= T_BUSY;
                        end
                        else
                        begin
                            pend_reg.minimum      <= '0;
                            pend_reg.out_of_range <= 1'b1;
                            state_reg             <= T_HOLD;
                        end
                    end
                end
                T_BUSY:
                begin
                    if (done_any.valid)
                    begin
                        if (done_any.is_query)
                        begin
                            pend_reg.minimum      <= done_any.best;
                            pend_reg.out_of_range <= 1'b0;
                            state_reg             <= T_HOLD;
                        end
                        else
                        begin
                            state_reg <= T_IDLE;
                        end
                    end
                end
                T_HOLD:
                begin
                    if (out_free)
                    begin
                        out_word_reg  <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_any.valid |-> state_reg == T_BUSY)
        else $error("cell finished while no word in flight");

    a_no_fall_off: assert property (@(posedge clk) disable iff (!rst_n)
        !tok[LEVELS].valid)
        else $error("word passed beyond last level");

    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_HOLD))
        else $error("result loaded outside hold state");

    a_start_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg.valid |=> !start_reg.valid && state_reg == T_BUSY)
        else $error("start pulse repeated or control lost");

endmodule

// ===== tb/sv/tb_min_line_envelope_tree_top.sv =====
// Testbench for min_line_envelope_tree_top: random and directed line inserts and
// minimum queries, checked against an in-bench envelope tree. Depends on lcht_pkg.
module tb_min_line_envelope_tree_top;
    import lcht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN  = DOMAIN_SPAN_DEF;
    localparam int NODES = NODE_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    // Envelope tree predictor and store of pending query answers.
    class envelope_board;
        logic signed [31:0] node_k[NODES];
        logic signed [31:0] node_b[NODES];
        logic signed [63:0] lo, hi;
        out_word_t pending[$];
        int mismatches;

        function void clear_tree();
            for (int i = 0; i < NODES; i++)
            begin
                node_k[i] = '0;
                node_b[i] = EMPTY_INTERCEPT;
            end
            lo = 0;
            hi = 1024;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [31:0] data);
            if (index == CFG_DOMAIN_LOW)
                lo = $signed(data);
            else if (index == CFG_DOMAIN_HIGH)
                hi = $signed(data);
        endfunction

        function logic signed [63:0] value_at(logic signed [63:0] k,
                                              logic signed [63:0] b,
                                              logic signed [63:0] x);
            return k * x + b;
        endfunction

        function bit span_ok();
            logic signed [63:0] s;
            s = hi - lo;
            return s >= 1 && s <= SPAN;
        endfunction

        function void add_line(logic signed [63:0] k, logic signed [63:0] b);
            logic signed [63:0] l, r, m, sk, sb;
            int idx;
            l = lo;
            r = hi;
            idx = 1;
            while (idx < NODES)
            begin
                m = (l + r) / 2;
                sk = node_k[idx];
                sb = node_b[idx];
                if (value_at(k, b, m) < value_at(sk, sb, m))
                begin
                    node_k[idx] = k[31:0];
                    node_b[idx] = b[31:0];
                    k = sk;
                    b = sb;
                end
                if (r - l <= 1)
                    return;
                if (k < node_k[idx])
                begin
                    l = m;
                    idx = idx * 2 + 1;
                end
                else
                begin
                    r = m;
                    idx = idx * 2;
                end
            end
        endfunction

        function logic signed [63:0] lowest_at(logic signed [63:0] p);
            logic signed [63:0] l, r, m, best, v;
            int idx;
            l = lo;
            r = hi;
            idx = 1;
            best = value_at(node_k[1], node_b[1], p);
            while (r - l > 1)
            begin
                m = (l + r) / 2;
                if (p < m)
                begin
                    r = m;
                    idx = idx * 2;
                end
                else
                begin
                    l = m;
                    idx = idx * 2 + 1;
                end
                if (idx >= NODES)
                    break;
                v = value_at(node_k[idx], node_b[idx], p);
                if (v < best)
                    best = v;
            end
            return best;
        endfunction

        function void note_word(in_word_t w);
            out_word_t e;
            logic signed [63:0] p;
            if (w.kind == KIND_INSERT)
            begin
                if (span_ok())
                    add_line(w.slope, w.intercept);
                return;
            end
            p = w.position;
            if (!span_ok() || p < lo || p >= hi)
            begin
                e.minimum = '0;
                e.out_of_range = 1'b1;
            end
            else
            begin
                e.minimum = lowest_at(p);
                e.out_of_range = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_word(out_word_t w);
            out_word_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: min=%0d oor=%0b", w.minimum, w.out_of_range);
                return;
            end
            e = pending.pop_front();
            if (w.minimum !== e.minimum || w.out_of_range !== e.out_of_range)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected min=%0d oor=%0b, got min=%0d oor=%0b",
                             e.minimum, e.out_of_range, w.minimum, w.out_of_range);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    envelope_board board = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    bit timed_out = 1'b0;

    // current domain, for picking positions
    int cur_lo = 0;
    int cur_hi = 1024;

    always #2 clk = ~clk;

    min_line_envelope_tree_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // result side: random stall, check on acceptance
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(out_word);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    // valid stays up after an accepted word only until the next call replaces
    // the word or drops valid in the same step
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_domain(int lo, int hi);
        wait_drained();
        write_reg(CFG_DOMAIN_LOW, lo);
        write_reg(CFG_DOMAIN_HIGH, hi);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic insert_line(int k, int b);
        in_word_t w;
        w = '0;
        w.kind = KIND_INSERT;
        w.slope = k;
        w.intercept = b;
        w.position = $urandom;
        send_word(w);
    endtask

    task automatic query_at(int p);
        in_word_t w;
        w.kind = KIND_QUERY;
        w.slope = $urandom;
        w.intercept = $urandom;
        w.position = p;
        send_word(w);
    endtask

    function automatic int any_word();
        return $urandom;
    endfunction

    function automatic int pick_position();
        int span;
        span = cur_hi - cur_lo;
        if ($urandom_range(9) == 0 || span <= 0 || span > SPAN)
            return $urandom_range(3) == 0 ? any_word() : cur_lo + $urandom_range(4) - 2;
        return cur_lo + $urandom_range(span - 1);
    endfunction

    task automatic random_items(int count);
        int k, b;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 50)
            begin
                case ($urandom_range(3))
                    0: begin k = any_word(); b = any_word(); end
                    1: begin k = $urandom_range(200) - 100; b = $urandom_range(20000) - 10000; end
                    2: begin k = $urandom_range(2000000) - 1000000; b = any_word(); end
                    default: begin k = $urandom_range(10) - 5; b = 1000000000 - $urandom_range(500); end
                endcase
                insert_line(k, b);
            end
            else
                query_at(pick_position());
        end
    endtask

    initial
    begin
        board.clear_tree();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, both kinds, empty tree, domain edges
        query_at(0);
        query_at(1023);
        query_at(1024);
        query_at(-1);
        query_at(32'sh7fffffff);
        query_at(32'sh80000000);
        insert_line(32'sh7fffffff, 32'sh80000000);
        insert_line(32'sh80000000, 32'sh7fffffff);
        insert_line(0, 0);
        insert_line(-1, 5);
        insert_line(3, -7);
        insert_line(3, -7);
        query_at(0);
        query_at(512);
        query_at(1023);
        query_at(511);

        // one-position domain, negative domain, invalid domains
        set_domain(5, 6);
        insert_line(2, 3);
        query_at(5);
        query_at(6);
        set_domain(-1024, 0);
        insert_line(-4, 100);
        query_at(-1024);
        query_at(-1);
        set_domain(0, 1025);
        insert_line(1, 1);
        query_at(0);
        set_domain(10, 10);
        query_at(10);
        set_domain(32'sh80000000, 32'sh7fffffff);
        query_at(0);

        // random phases with varying domains, idling and output stalls
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            case (ph)
                0: set_domain(0, 1024);
                1: set_domain(-3, 9);
                2: set_domain(32'sh7ffffc00, 32'sh7fffffff);
                3: set_domain(32'sh80000000, 32'sh80000400);
                4: set_domain(-500, 524);
                5: set_domain(100, 101);
                6: set_domain(0, 1024);
                default: set_domain(7, 300);
            endcase
            random_items(100);
            if (ph == 3)
            begin
                // hold off until every answer is back
                in_valid <= 1'b0;
                while (board.pending.size() != 0)
                    @(posedge clk);
                random_items(10);
            end
        end
        // domain reinterpretation without clearing, then invalid domain noise
        set_domain(0, 512);
        random_items(20);
        set_domain(9, 3);
        random_items(10);

        stall_pct = 0;
        wait_drained();
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
